[sv/fbpa_pkg.sv]
// shared constants and types for the fixed block pool allocator
`default_nettype none
package fbpa_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int COUNT_W = $clog2(MAX_SLOTS + 1);

  localparam int BYTES_W = 16;
  localparam int LIMIT_W = 7;
  localparam int HANDLE_W = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam int CMP_W = (HANDLE_W > COUNT_W) ? HANDLE_W : COUNT_W;
  localparam int LCMP_W = (LIMIT_W > COUNT_W) ? LIMIT_W : COUNT_W;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_LIMIT = 1'b1;

  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = 16'd64;
  localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 7'd64;

  localparam logic [STATUS_W-1:0] ST_GIVEN = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_POOL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd5;

  typedef struct packed {
    logic capture;
    logic issue_pop;
    logic finish_exec;
    logic finish_pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[sv/fixed_block_pool_allocator_unit.sv]
// top level of the fixed block pool allocator
// the result is registered from the execute state, or from the pop state when a freed slot is reused
// in_stall is held from capture until the result is written, so a new transaction waits for
// the execute state, plus the pop state with the registered read of the free stack memory on reuse;
// the next input is taken while a finished result still waits at the output register
// synchronous reset: all slots uncreated and not in use, config back to 64 bytes and 64 slots
`default_nettype none
module fixed_block_pool_allocator_unit
  import fbpa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   command,
  input  wire logic [BYTES_W-1:0]     request_bytes,
  input  wire logic [HANDLE_W-1:0]    handle,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [STATUS_W-1:0]         status,
  output logic [SLOT_W-1:0]           slot
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbpa_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .request_bytes (request_bytes),
    .handle        (handle),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .slot          (slot)
  );

endmodule
`default_nettype wire

[sv/fbpa_ctrl.sv]
// controller state machine of the fixed block pool allocator
`default_nettype none
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.pop) begin
          cmd.issue_pop = 1'b1;
          state_next = S_POP;
        end else if (stat.out_free) begin
          cmd.finish_exec = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.finish_pop = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[sv/fbpa_dpath.sv]
// datapath of the fixed block pool allocator: config, slot state, free stack, result
`default_nettype none
module fbpa_dpath
  import fbpa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   command,
  input  wire logic [BYTES_W-1:0]     request_bytes,
  input  wire logic [HANDLE_W-1:0]    handle,
  input  wire ctrl_cmd_t              cmd,
  output dp_stat_t                    stat,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [STATUS_W-1:0]         status,
  output logic [SLOT_W-1:0]           slot
);

  logic [BYTES_W-1:0]  block_bytes;
  logic [LIMIT_W-1:0]  slot_limit;
  logic [MAX_SLOTS-1:0] in_use;
  logic [COUNT_W-1:0]  free_count;
  logic [COUNT_W-1:0]  created_count;

  logic                command_q;
  logic [BYTES_W-1:0]  request_q;
  logic [HANDLE_W-1:0] handle_q;

  logic [SLOT_W-1:0] stack_mem [MAX_SLOTS];
  logic [SLOT_W-1:0] pop_data;

  logic                too_large;
  logic                pool_full;
  logic                not_in_pool;
  logic                already_free;
  logic                do_create;
  logic                do_free;
  logic [SLOT_W-1:0]   handle_slot;
  logic [COUNT_W-1:0]  pop_count;
  logic [STATUS_W-1:0] exec_status;
  logic [SLOT_W-1:0]   exec_slot;

  assign handle_slot = handle_q[SLOT_W-1:0];
  assign pop_count = free_count - COUNT_W'(1);

  always_comb begin
    too_large = (request_q > block_bytes);
    pool_full = (LCMP_W'(created_count) >= LCMP_W'(slot_limit)) ||
                (created_count == COUNT_W'(MAX_SLOTS));
    not_in_pool = (CMP_W'(handle_q) >= CMP_W'(created_count)) ||
                  (CMP_W'(handle_q) >= CMP_W'(MAX_SLOTS));
    already_free = !in_use[handle_slot];
    stat.pop = (command_q == CMD_ALLOC) && !too_large && (free_count != '0);
    stat.out_free = !out_valid || !out_stall;
    do_create = 1'b0;
    do_free = 1'b0;
    exec_slot = '0;
    if (command_q == CMD_ALLOC) begin
      if (too_large) begin
        exec_status = ST_TOO_LARGE;
      end else if (pool_full) begin
        exec_status = ST_FULL;
      end else begin
        exec_status = ST_GIVEN;
        exec_slot = created_count[SLOT_W-1:0];
        do_create = 1'b1;
      end
    end else begin
      if (not_in_pool) begin
        exec_status = ST_NOT_IN_POOL;
      end else if (already_free) begin
        exec_status = ST_ALREADY_FREE;
        exec_slot = handle_slot;
      end else begin
        exec_status = ST_FREED;
        exec_slot = handle_slot;
        do_free = 1'b1;
      end
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (cmd.finish_exec && do_free && (free_count < COUNT_W'(MAX_SLOTS))) begin
      stack_mem[free_count[SLOT_W-1:0]] <= handle_slot;
    end
    if (cmd.issue_pop) begin
      pop_data <= stack_mem[pop_count[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_q <= command;
      request_q <= request_bytes;
      handle_q <= handle;
    end
    if (cmd.finish_exec) begin
      status <= exec_status;
      slot <= exec_slot;
    end else if (cmd.finish_pop) begin
      status <= ST_GIVEN;
      slot <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BLOCK_BYTES_RESET;
      slot_limit <= SLOT_LIMIT_RESET;
      in_use <= '0;
      free_count <= '0;
      created_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BLOCK_BYTES: block_bytes <= cfg_data[BYTES_W-1:0];
          CFG_SLOT_LIMIT: slot_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.issue_pop) begin
        free_count <= pop_count;
      end
      if (cmd.finish_exec && do_create) begin
        created_count <= created_count + COUNT_W'(1);
        in_use[created_count[SLOT_W-1:0]] <= 1'b1;
      end
      if (cmd.finish_exec && do_free) begin
        in_use[handle_slot] <= 1'b0;
        if (free_count < COUNT_W'(MAX_SLOTS)) begin
          free_count <= free_count + COUNT_W'(1);
        end
      end
      if (cmd.finish_pop) begin
        in_use[pop_data] <= 1'b1;
      end
      if (cmd.finish_exec || cmd.finish_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
